### sv/kdlp_pkg.sv
// shared constants for the keypad debounce and long-press core
`timescale 1ns / 1ps
`default_nettype none
package kdlp_pkg;
	localparam int unsigned FIELD_W = 8;
	localparam int unsigned CNT_W = 8;
	localparam logic [CNT_W-1:0] RESET_THRESHOLD = 8'd50;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [CNT_W-1:0] cnt_t;
endpackage
`default_nettype wire

### sv/keypad_debounce_long_press_core.sv
// keypad debounce and long-press detect core, one scan tick per word
//
// channel   direction  handshake                       payload
// in        to core    in_valid / in_stall             button_levels
// out       from core  out_valid / out_stall           release_events, held_keys,
//                                                      long_press_keys
// cfg       to core    cfg_valid / cfg_ready           long_press_ticks
//
// one word per cycle sustained while out_stall is low; each word passes through the input
// register, then the per-key update into the result register
// out_stall holds the result register and stalls the input only when the input
// register is also full
// reset: all keys released, no key held, counters clear, threshold 50
// cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
module keypad_debounce_long_press_core #(
	parameter int unsigned NUM_KEYS = 8,
	parameter int unsigned WINDOW_SAMPLES = 6
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  kdlp_pkg::field_t button_levels,
	output logic                  out_valid,
	input  wire                   out_stall,
	output kdlp_pkg::field_t      release_events,
	output kdlp_pkg::field_t      held_keys,
	output kdlp_pkg::field_t      long_press_keys,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  kdlp_pkg::cnt_t  long_press_ticks
);
	import kdlp_pkg::*;

	localparam int unsigned HIST_D = WINDOW_SAMPLES - 1;

	logic                valid_s1;
	field_t              levels_s1;
	logic                valid_s2;
	field_t              release_s2;
	field_t              held_s2;
	field_t              long_s2;
	cnt_t                thr_q;
	logic [NUM_KEYS-1:0] hist_q [HIST_D];
	logic [NUM_KEYS-1:0] held_q;
	logic [NUM_KEYS-1:0] long_q;
	cnt_t                cnt_q [NUM_KEYS];

	logic                adv2;
	logic [NUM_KEYS-1:0] sample;
	logic [NUM_KEYS-1:0] any_high;
	logic [NUM_KEYS-1:0] held_d;
	logic [NUM_KEYS-1:0] long_d;
	logic [NUM_KEYS-1:0] rel_d;
	cnt_t                cnt_d [NUM_KEYS];
	field_t              rel_f;
	field_t              held_f;
	field_t              long_f;

	assign adv2 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv2;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign release_events = release_s2;
	assign held_keys = held_s2;
	assign long_press_keys = long_s2;

	// keys above the field width read pressed
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_sample
		if (k < FIELD_W) begin : g_in
			assign sample[k] = levels_s1[k];
		end else begin : g_zero
			assign sample[k] = 1'b0;
		end
	end

	always_comb begin
		any_high = sample;
		for (int i = 0; i < HIST_D; i++) begin
			any_high = any_high | hist_q[i];
		end
	end

	// per-key held, long and counter update
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			held_d[k] = held_q[k];
			long_d[k] = long_q[k];
			rel_d[k] = 1'b0;
			cnt_d[k] = cnt_q[k];
			if (!any_high[k]) begin
				if (!held_q[k]) begin
					held_d[k] = 1'b1;
					cnt_d[k] = '0;
				end else if (!long_q[k]) begin
					if (cnt_q[k] < thr_q) begin
						cnt_d[k] = cnt_q[k] + cnt_t'(1);
					end else begin
						long_d[k] = 1'b1;
						cnt_d[k] = '0;
					end
				end
			end else begin
				rel_d[k] = held_q[k];
				held_d[k] = 1'b0;
				long_d[k] = 1'b0;
				cnt_d[k] = '0;
			end
		end
	end

	for (genvar b = 0; b < FIELD_W; b++) begin : g_out
		if (b < NUM_KEYS) begin : g_key
			assign rel_f[b] = rel_d[b];
			assign held_f[b] = held_d[b];
			assign long_f[b] = long_d[b];
		end else begin : g_none
			assign rel_f[b] = 1'b0;
			assign held_f[b] = 1'b0;
			assign long_f[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RESET_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= long_press_ticks;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			levels_s1 <= button_levels;
		end
	end

	// key state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			held_q <= '0;
			long_q <= '0;
			for (int i = 0; i < HIST_D; i++) begin
				hist_q[i] <= '1;
			end
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			if (adv2) begin
				valid_s2 <= 1'b1;
				held_q <= held_d;
				long_q <= long_d;
				hist_q[0] <= sample;
				for (int i = 1; i < HIST_D; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				for (int k = 0; k < NUM_KEYS; k++) begin
					cnt_q[k] <= cnt_d[k];
				end
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			release_s2 <= rel_f;
			held_s2 <= held_f;
			long_s2 <= long_f;
		end
	end

	a_long_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		(long_q & ~held_q) == '0)
		else $error("long flag set on a key that is not held");

	a_release_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (release_s2 & held_s2) == '0)
		else $error("released key still reported held");

	a_release_was_held: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> (release_s2 & ~$past(held_f | rel_f)) == '0 &&
			(release_s2 & held_s2) == '0)
		else $error("release word on a key that was not held");

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_chk
		a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
			(long_q[k] || !held_q[k]) |-> cnt_q[k] == '0)
			else $error("hold counter nonzero outside counting phase");
	end
endmodule
`default_nettype wire

### test/tb_keypad_debounce_long_press_core.sv
// testbench for the keypad debounce and long-press core: predicted results vs core words
`timescale 1ns / 1ps
`default_nettype none
module tb_keypad_debounce_long_press_core;
	import kdlp_pkg::*;

	localparam int unsigned KEYS = 8;
	localparam int unsigned WINDOW = 6;
	localparam int unsigned STALL_LIMIT = 1000;

	typedef struct packed {
		field_t released;
		field_t held;
		field_t long_held;
	} scan_result_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	field_t button_levels;
	logic   out_valid;
	logic   out_stall;
	field_t release_events;
	field_t held_keys;
	field_t long_press_keys;
	logic   cfg_valid;
	logic   cfg_ready;
	cnt_t   long_press_ticks;

	// predicted key state
	field_t sample_win[WINDOW];
	int unsigned sample_slot;
	field_t held_mask;
	field_t long_mask;
	cnt_t   hold_count[KEYS];
	cnt_t   press_threshold;

	scan_result_t expected_scans[$];
	int unsigned  error_count;
	int unsigned  quiet_cycles;
	bit           gaps_on;
	bit           stalls_on;

	keypad_debounce_long_press_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.button_levels   (button_levels),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.release_events  (release_events),
		.held_keys       (held_keys),
		.long_press_keys (long_press_keys),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.long_press_ticks(long_press_ticks)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void clear_key_state();
		for (int s = 0; s < WINDOW; s++)
			sample_win[s] = '1;
		sample_slot = 0;
		held_mask = '0;
		long_mask = '0;
		for (int k = 0; k < KEYS; k++)
			hold_count[k] = '0;
		press_threshold = RESET_THRESHOLD;
	endfunction

	function automatic scan_result_t debounce_scan(input field_t levels);
		field_t any_high;
		field_t released;
		any_high = '0;
		released = '0;
		sample_win[sample_slot] = levels;
		sample_slot = (sample_slot + 1 >= WINDOW) ? 0 : sample_slot + 1;
		for (int s = 0; s < WINDOW; s++)
			any_high |= sample_win[s];
		for (int k = 0; k < KEYS; k++) begin
			if (!any_high[k]) begin
				if (!held_mask[k]) begin
					held_mask[k] = 1'b1;
					hold_count[k] = '0;
				end else if (!long_mask[k]) begin
					if (hold_count[k] < press_threshold) begin
						hold_count[k] = hold_count[k] + 1'b1;
					end else begin
						long_mask[k] = 1'b1;
						hold_count[k] = '0;
					end
				end
			end else begin
				released[k] = held_mask[k];
				held_mask[k] = 1'b0;
				long_mask[k] = 1'b0;
				hold_count[k] = '0;
			end
		end
		return '{released: released, held: held_mask, long_held: long_mask};
	endfunction

	task automatic flag_error(input string what, input field_t got, input field_t want);
		if (error_count < 40)
			$display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// monitor: predict on accepted input words, check accepted result words
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (cfg_valid && cfg_ready)
				press_threshold = long_press_ticks;
			if (in_valid && !in_stall)
				expected_scans.push_back(debounce_scan(button_levels));
			if (out_valid && !out_stall) begin
				if (expected_scans.size() == 0) begin
					flag_error("unexpected word", release_events, '0);
				end else begin
					want = expected_scans.pop_front();
					if (release_events !== want.released)
						flag_error("release_events", release_events, want.released);
					if (held_keys !== want.held)
						flag_error("held_keys", held_keys, want.held);
					if (long_press_keys !== want.long_held)
						flag_error("long_press_keys", long_press_keys, want.long_held);
				end
			end
		end
	end

	// receiver stalls in bursts
	always begin
		@(negedge clk);
		if (stalls_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 14)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	task automatic send_word(input field_t levels);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		button_levels <= levels;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_repeat(input field_t levels, input int count);
		for (int i = 0; i < count; i++)
			send_word(levels);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_scans.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(input cnt_t ticks);
		wait_results_done();
		cfg_valid <= 1'b1;
		long_press_ticks <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// short glitch must not register as a press; keys low on all six words do
	task automatic test_bounce();
		send_word(8'hFF);
		send_repeat(8'h00, 5);
		send_word(8'hAA);
	endtask

	// full press of every key, then release of all at once
	task automatic test_press_release();
		send_repeat(8'h00, 6);
		send_word(8'hFF);
	endtask

	// threshold zero sets the long flag on the second held word
	task automatic test_threshold_zero();
		write_threshold(8'd0);
		send_repeat(8'hF0, 8);
		send_word(8'hFF);
	endtask

	// largest threshold, keys held long enough to reach it
	task automatic test_threshold_max();
		field_t mask;
		write_threshold(8'd255);
		mask = field_t'($urandom) | 8'h81;
		for (int i = 0; i < 268; i++)
			send_word(~mask | (field_t'($urandom) & field_t'($urandom) & ~mask));
		send_word(8'hFF);
	endtask

	// press runs of random masks and lengths with glitches and noise
	task automatic test_random_presses(input cnt_t ticks, input int words);
		int sent;
		int run_len;
		field_t mask;
		field_t levels;
		write_threshold(ticks);
		sent = 0;
		while (sent < words) begin
			mask = ($urandom_range(0, 3) == 0) ? field_t'(1 << $urandom_range(0, 7))
			                                  : field_t'($urandom);
			run_len = $urandom_range(1, int'(press_threshold) + 16);
			for (int i = 0; i < run_len && sent < words; i++) begin
				levels = ~mask;
				if ($urandom_range(0, 3) == 0)
					levels ^= field_t'($urandom) & field_t'($urandom) & ~mask;
				if ($urandom_range(0, 15) == 0)
					levels ^= field_t'(1 << $urandom_range(0, 7));
				if ($urandom_range(0, 19) == 0)
					levels = field_t'($urandom);
				send_word(levels);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		button_levels = '1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		long_press_ticks = RESET_THRESHOLD;
		error_count = 0;
		quiet_cycles = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		clear_key_state();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_bounce();
		test_press_release();
		test_threshold_zero();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_threshold_max();
		test_random_presses(8'd1, 400);
		test_random_presses(8'd7, 400);
		test_random_presses(cnt_t'($urandom_range(1, 40)), 400);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		test_random_presses(8'd2, 400);

		wait_results_done();
		repeat (8) @(posedge clk);
		if (expected_scans.size() != 0)
			flag_error("missing words", '0, field_t'(expected_scans.size()));
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
